[sv/rfa_pkg.sv]
// Shared types and constants for the rational fraction ALU.
// Used by the channel interfaces, the shared arithmetic unit and the top level.
// No dependencies.
package rfa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int WIDE_BITS  = 64;
    localparam logic [WIDE_BITS-1:0] RES_LIMIT = (WIDE_BITS'(1) << (VALUE_BITS - 1)) - 1;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        UOP_GCD = 2'd0,
        UOP_MUL = 2'd1,
        UOP_DIV = 2'd2
    } t_uop;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_G1, S_G2, S_DV1, S_DV2, S_DV3, S_DV4,
        S_MU1, S_MU2, S_MU3, S_COMB, S_ZCHK, S_GR, S_DVR1, S_DVR2,
        S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        t_uop                 op;
        logic [WIDE_BITS-1:0] a;
        logic [WIDE_BITS-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [WIDE_BITS-1:0] res;
    } t_unit_rsp;

endpackage

[sv/rfa_if.sv]
// Valid/ready channel interfaces for the rational fraction ALU.
// Depends on rfa_pkg for the item types.
interface rfa_in_if;
    logic              valid;
    logic              ready;
    rfa_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rfa_out_if;
    logic               valid;
    logic               ready;
    rfa_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/rfa_unit.sv]
// Shared iterative arithmetic unit: binary gcd, shift-add multiply, restoring divide.
// One step per cycle on 64-bit operands. Depends on rfa_pkg.
module rfa_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfa_pkg::t_unit_req i_req,
    output rfa_pkg::t_unit_rsp o_rsp
);
    localparam int W = rfa_pkg::WIDE_BITS;

    logic          r_busy;
    rfa_pkg::t_uop r_op;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_acc;
    logic [6:0]    r_cnt;
    logic [6:0]    r_k;

    logic [W:0]   rem2;
    logic [W:0]   diff;
    logic         ge;
    logic         gcd_end;
    logic         done;
    logic [W-1:0] res;

    always_comb begin
        rem2    = {r_acc, r_a[W-1]};
        diff    = rem2 - {1'b0, r_b};
        ge      = rem2 >= {1'b0, r_b};
        gcd_end = (r_a == '0) || (r_b == '0);
        unique case (r_op)
            rfa_pkg::UOP_GCD: done = r_busy && gcd_end;
            default:          done = r_busy && (r_cnt == '0);
        endcase
        unique case (r_op)
            rfa_pkg::UOP_GCD: res = (r_a | r_b) << r_k[5:0];
            rfa_pkg::UOP_MUL: res = r_acc;
            default:          res = r_a;
        endcase
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = done;
    assign o_rsp.res  = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start && !r_busy) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
            r_k   <= '0;
            r_cnt <= (i_req.op == rfa_pkg::UOP_MUL) ? 7'd32 : 7'd64;
        end else if (r_busy && !done) begin
            unique case (r_op)
                rfa_pkg::UOP_GCD: begin
                    // Stein's algorithm: common factors of two are counted in r_k.
                    priority if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 7'd1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= (r_a - r_b) >> 1;
                    end else begin
                        r_b <= (r_b - r_a) >> 1;
                    end
                end
                rfa_pkg::UOP_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a   <= r_a << 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt - 7'd1;
                end
                default: begin
                    r_acc <= ge ? diff[W-1:0] : rem2[W-1:0];
                    r_a   <= {r_a[W-2:0], ge};
                    r_cnt <= r_cnt - 7'd1;
                end
            endcase
        end
    end
endmodule

[sv/rational_fraction_alu.sv]
// Top level of the rational fraction ALU: sequencer around one shared unit.
// Depends on rfa_pkg, rfa_if (rfa_in_if, rfa_out_if) and rfa_unit.
//
//  Port    Dir  Payload                               Accepted when
//  i_in    in   mode, a_num, a_den, b_num, b_den      valid && ready
//  o_out   out  res_num, res_den, status              valid && ready
//
// One item at a time: i_in.ready is high only while the sequencer is idle.
// An item runs its gcd, divide and multiply operations in sequence on the shared unit.
// Errors found on the operands skip the shared unit and go from the check state to the output.
// The result is held in an output register until o_out.ready takes it.
// Reset is synchronous and active low and returns the sequencer to idle.
module rational_fraction_alu (
    input  logic i_clk,
    input  logic i_rst_n,
    rfa_in_if.sink    i_in,
    rfa_out_if.source o_out
);
    localparam int W = rfa_pkg::WIDE_BITS;

    rfa_pkg::t_state    r_state, n_state;
    rfa_pkg::t_mode     r_mode;
    logic [31:0]        r_am, r_bm;
    logic [30:0]        r_ad, r_bd;
    logic               r_an, r_bn, r_s2, r_neg;
    logic [W-1:0]       r_t0, r_t1, r_t2, r_t3, r_rm, r_rd;
    logic               r_started;
    rfa_pkg::t_out_item r_res;

    rfa_pkg::t_unit_req req;
    rfa_pkg::t_unit_rsp rsp;

    logic         is_add;
    logic         op_state;
    logic [W-1:0] w_am, w_bm, w_ad, w_bd, w_d1, w_n2, g_res;
    logic [31:0]  am_in, bm_in;
    logic         bad_in;
    logic         ovf;
    logic [31:0]  out_num;

    rfa_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_comb begin
        is_add = (r_mode == rfa_pkg::MODE_ADD) || (r_mode == rfa_pkg::MODE_SUB);
        w_am   = {32'b0, r_am};
        w_bm   = {32'b0, r_bm};
        w_ad   = {33'b0, r_ad};
        w_bd   = {33'b0, r_bd};
        w_d1   = (r_mode == rfa_pkg::MODE_MUL) ? w_bd : w_bm;
        w_n2   = (r_mode == rfa_pkg::MODE_MUL) ? w_bm : w_bd;
        // A gcd of zero can only come from two zero operands; it divides as one.
        g_res  = (rsp.res == '0) ? W'(1) : rsp.res;
        am_in  = i_in.data.a_num[31] ? (~i_in.data.a_num + 32'd1) : i_in.data.a_num;
        bm_in  = i_in.data.b_num[31] ? (~i_in.data.b_num + 32'd1) : i_in.data.b_num;
        bad_in = (r_ad == '0) || (r_bd == '0)
                 || ((r_mode == rfa_pkg::MODE_DIV) && (r_bm == '0));
        ovf    = (r_rd > rfa_pkg::RES_LIMIT)
                 || (r_rm > (rfa_pkg::RES_LIMIT + W'(r_neg)));
        out_num = r_neg ? (~r_rm[31:0] + 32'd1) : r_rm[31:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rfa_pkg::S_IDLE:  if (i_in.valid) n_state = rfa_pkg::S_CHECK;
            rfa_pkg::S_CHECK: n_state = bad_in ? rfa_pkg::S_OUT : rfa_pkg::S_G1;
            rfa_pkg::S_G1:    if (rsp.done) n_state = is_add ? rfa_pkg::S_DV1 : rfa_pkg::S_G2;
            rfa_pkg::S_G2:    if (rsp.done) n_state = rfa_pkg::S_DV1;
            rfa_pkg::S_DV1:   if (rsp.done) n_state = rfa_pkg::S_DV2;
            rfa_pkg::S_DV2:   if (rsp.done) n_state = is_add ? rfa_pkg::S_MU1 : rfa_pkg::S_DV3;
            rfa_pkg::S_DV3:   if (rsp.done) n_state = rfa_pkg::S_DV4;
            rfa_pkg::S_DV4:   if (rsp.done) n_state = rfa_pkg::S_MU1;
            rfa_pkg::S_MU1:   if (rsp.done) n_state = rfa_pkg::S_MU2;
            rfa_pkg::S_MU2:   if (rsp.done) n_state = is_add ? rfa_pkg::S_MU3 : rfa_pkg::S_ZCHK;
            rfa_pkg::S_MU3:   if (rsp.done) n_state = rfa_pkg::S_COMB;
            rfa_pkg::S_COMB:  n_state = rfa_pkg::S_ZCHK;
            rfa_pkg::S_ZCHK:  n_state = (r_rm == '0) ? rfa_pkg::S_OUT : rfa_pkg::S_GR;
            rfa_pkg::S_GR:    if (rsp.done) n_state = rfa_pkg::S_DVR1;
            rfa_pkg::S_DVR1:  if (rsp.done) n_state = rfa_pkg::S_DVR2;
            rfa_pkg::S_DVR2:  if (rsp.done) n_state = rfa_pkg::S_FIN;
            rfa_pkg::S_FIN:   n_state = rfa_pkg::S_OUT;
            rfa_pkg::S_OUT:   if (o_out.ready) n_state = rfa_pkg::S_IDLE;
            default:          n_state = rfa_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshakes and the request to the shared unit.
    always_comb begin
        i_in.ready  = (r_state == rfa_pkg::S_IDLE);
        o_out.valid = (r_state == rfa_pkg::S_OUT);
        o_out.data  = r_res;
        op_state    = 1'b1;
        req.op      = rfa_pkg::UOP_DIV;
        req.a       = '0;
        req.b       = '0;
        unique case (r_state)
            rfa_pkg::S_G1: begin
                req.op = rfa_pkg::UOP_GCD;
                req.a  = is_add ? w_ad : w_am;
                req.b  = is_add ? w_bd : w_d1;
            end
            rfa_pkg::S_G2: begin
                req.op = rfa_pkg::UOP_GCD;
                req.a  = w_n2;
                req.b  = w_ad;
            end
            rfa_pkg::S_DV1: begin
                req.a = is_add ? w_ad : w_am;
                req.b = r_t0;
            end
            rfa_pkg::S_DV2: begin
                req.a = is_add ? w_bd : w_d1;
                req.b = r_t0;
            end
            rfa_pkg::S_DV3: begin
                req.a = w_n2;
                req.b = r_t3;
            end
            rfa_pkg::S_DV4: begin
                req.a = w_ad;
                req.b = r_t3;
            end
            rfa_pkg::S_MU1: begin
                req.op = rfa_pkg::UOP_MUL;
                req.a  = is_add ? w_ad : r_t2;
                req.b  = is_add ? r_t2 : r_t3;
            end
            rfa_pkg::S_MU2: begin
                req.op = rfa_pkg::UOP_MUL;
                req.a  = is_add ? w_am : r_t1;
                req.b  = is_add ? r_t2 : r_t0;
            end
            rfa_pkg::S_MU3: begin
                req.op = rfa_pkg::UOP_MUL;
                req.a  = w_bm;
                req.b  = r_t1;
            end
            rfa_pkg::S_GR: begin
                req.op = rfa_pkg::UOP_GCD;
                req.a  = r_rm;
                req.b  = r_rd;
            end
            rfa_pkg::S_DVR1: begin
                req.a = r_rm;
                req.b = r_t0;
            end
            rfa_pkg::S_DVR2: begin
                req.a = r_rd;
                req.b = r_t0;
            end
            default: op_state = 1'b0;
        endcase
        req.start = op_state && !r_started;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rfa_pkg::S_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rsp.done) begin
                r_started <= 1'b0;
            end else if (req.start) begin
                r_started <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rfa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    r_mode <= rfa_pkg::t_mode'(i_in.data.mode);
                    r_am   <= am_in;
                    r_bm   <= bm_in;
                    r_an   <= i_in.data.a_num[31];
                    r_bn   <= i_in.data.b_num[31];
                    r_ad   <= i_in.data.a_den;
                    r_bd   <= i_in.data.b_den;
                end
            end
            rfa_pkg::S_CHECK: begin
                r_s2  <= (r_mode == rfa_pkg::MODE_SUB) ? !r_bn : r_bn;
                r_neg <= r_an ^ r_bn;
                if (bad_in) begin
                    r_res.res_num <= '0;
                    r_res.res_den <= 31'd1;
                    r_res.status  <= rfa_pkg::ST_DIVZERO;
                end
            end
            rfa_pkg::S_G1:   if (rsp.done) r_t0 <= g_res;
            rfa_pkg::S_G2:   if (rsp.done) r_t3 <= g_res;
            rfa_pkg::S_DV1:  if (rsp.done) r_t1 <= rsp.res;
            rfa_pkg::S_DV2:  if (rsp.done) r_t2 <= rsp.res;
            rfa_pkg::S_DV3:  if (rsp.done) r_t0 <= rsp.res;
            rfa_pkg::S_DV4:  if (rsp.done) r_t3 <= rsp.res;
            rfa_pkg::S_MU1:  if (rsp.done) r_rd <= rsp.res;
            rfa_pkg::S_MU2: begin
                if (rsp.done) begin
                    if (is_add) begin
                        r_t0 <= rsp.res;
                    end else begin
                        r_rm <= rsp.res;
                    end
                end
            end
            rfa_pkg::S_MU3:  if (rsp.done) r_t3 <= rsp.res;
            rfa_pkg::S_COMB: begin
                // Both scaled numerators sit in r_t0 and r_t3; combine by sign.
                if (r_an == r_s2) begin
                    r_rm  <= r_t0 + r_t3;
                    r_neg <= r_an;
                end else if (r_t0 >= r_t3) begin
                    r_rm  <= r_t0 - r_t3;
                    r_neg <= r_an;
                end else begin
                    r_rm  <= r_t3 - r_t0;
                    r_neg <= r_s2;
                end
            end
            rfa_pkg::S_ZCHK: begin
                if (r_rm == '0) begin
                    r_res.res_num <= '0;
                    r_res.res_den <= 31'd1;
                    r_res.status  <= rfa_pkg::ST_OK;
                end
            end
            rfa_pkg::S_GR:   if (rsp.done) r_t0 <= g_res;
            rfa_pkg::S_DVR1: if (rsp.done) r_rm <= rsp.res;
            rfa_pkg::S_DVR2: if (rsp.done) r_rd <= rsp.res;
            rfa_pkg::S_FIN: begin
                if (ovf) begin
                    r_res.res_num <= '0;
                    r_res.res_den <= 31'd1;
                    r_res.status  <= rfa_pkg::ST_OVERFLOW;
                end else begin
                    r_res.res_num <= out_num;
                    r_res.res_den <= r_rd[30:0];
                    r_res.status  <= rfa_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.status != rfa_pkg::ST_OK))
        |-> (o_out.data.res_num == '0) && (o_out.data.res_den == 31'd1))
        else $error("error result is not 0/1");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.res_den != '0))
        else $error("result denominator is zero");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.start |-> !rsp.busy)
        else $error("shared unit started while busy");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> $past(req.start) || $past(rsp.busy))
        else $error("shared unit finished without a request");
endmodule
